// ===== rtl/crs_pkg.sv =====
package crs_pkg;

   localparam logic [3:0]  MAX_NULL_LIMIT    = 4'd15;
   localparam logic [3:0]  RESET_NULL_CAP    = 4'd2;
   localparam logic [31:0] RESET_START_FRAME = 32'd0;
   localparam logic [2:0]  RESET_CHANNEL     = 3'd3;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [15:0] PARITY_MASK   = 16'h7f7f;
   localparam logic [14:0] CTRL_OR       = 15'h090f;
   localparam logic [14:0] CTRL_MATCH    = 15'h1d2f;
   localparam logic [14:0] XDS_OR        = 15'h0f7f;
   localparam logic [14:0] CR_OR         = 15'h0900;
   localparam logic [14:0] CR_MATCH      = 15'h1d2d;
   localparam logic [14:0] LO_MASK       = 15'h002f;
   localparam logic [14:0] HI_MASK       = 15'h0f00;
   localparam logic [14:0] FIELD_MASK    = 15'h0100;
   localparam logic [14:0] PAIR_MASK     = 15'h0800;
   localparam logic [5:0]  LO_EOC        = 6'h2c;
   localparam logic [5:0]  LO_EDM        = 6'h2f;
   localparam logic [5:0]  LO_CR         = 6'h2d;
   localparam logic [3:0]  XDS_END_HI    = 4'hf;

   typedef enum logic [0:0] {
      REG_NULL_CAP    = 1'b0,
      REG_START_FRAME = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] byte_high;
      logic [7:0] byte_low;
   } req_type;

   typedef struct packed {
      logic [14:0] caption_word;
      logic        record_start;
      logic [31:0] record_frame;
      logic        run_last;
   } rsp_type;

   typedef struct packed {
      logic [14:0] word;
      logic        start;
      logic [31:0] frame;
      logic [3:0]  nulls;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } track_out_type;

   typedef struct packed {
      logic [3:0]  null_cap;
      logic        frame_load;
      logic [31:0] start_frame;
   } csr_out_type;

endpackage

// ===== rtl/caption_record_segmenter.sv =====
// channel   direction  handshake          payload
// req       in         req_valid/ready    byte_high, byte_low
// rsp       out        rsp_valid/ready    caption_word, record_start, record_frame, run_last
// csr       in         psel/penable       null limit (0x0), start_frame (0x4)
//
// a pair is held in the input register, then updates the record state and loads
// the result register, from which its first beat is offered
// a pair gives 0 beats (null) or 1 + pending nulls beats, up to 16, one beat per cycle
// while rsp_ready is high, and the result register takes a new pair as its last beat leaves,
// so one-beat pairs stream at one per cycle while rsp_ready is high
// reset is synchronous and returns record state and valid flags to their defaults
// rsp_ready low holds the result register; one more pair waits in the input register
module caption_record_segmenter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  crs_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output crs_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [crs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import crs_pkg::*;

   logic          in_valid_ff;
   req_type       in_data_ff;
   logic          move;
   logic          free;
   csr_out_type   csr_out;
   track_out_type track_out;

   assign move      = in_valid_ff && free;
   assign req_ready = !in_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   crs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr_out (csr_out)
   );

   crs_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (move),
      .req       (in_data_ff),
      .csr_out   (csr_out),
      .track_out (track_out)
   );

   crs_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (move && track_out.valid),
      .job       (track_out.job),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_null_beats: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.run_last) |->
         (rsp_data.caption_word == 15'd0 && !rsp_data.record_start))
      else $error("null beat carries a word or start flag");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.run_last) |=>
         (rsp_valid && $stable(rsp_data.record_frame)))
      else $error("result run broken before its last beat");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !move) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("buffered pair lost while result register busy");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !in_valid_ff))
      else $error("beats pending after reset");

endmodule

// ===== rtl/crs_csr.sv =====
module crs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [crs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [crs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [crs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output crs_pkg::csr_out_type             csr_out
);
   import crs_pkg::*;

   logic [3:0]    null_cap_ff;
   logic [31:0]   start_frame_ff;
   logic          wr_en;
   csr_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         null_cap_ff    <= RESET_NULL_CAP;
         start_frame_ff <= RESET_START_FRAME;
      end else if (wr_en) begin
         case (index)
            REG_NULL_CAP:    null_cap_ff    <= pwdata[3:0];
            REG_START_FRAME: start_frame_ff <= pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_NULL_CAP:    prdata = {{(CSR_DATA_W-4){1'b0}}, null_cap_ff};
         REG_START_FRAME: prdata = start_frame_ff;
         default:         prdata = '0;
      endcase
   end

   assign csr_out.null_cap    = null_cap_ff;
   assign csr_out.frame_load  = wr_en && (index == REG_START_FRAME);
   assign csr_out.start_frame = pwdata[31:0];

endmodule

// ===== rtl/crs_track.sv =====
module crs_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  crs_pkg::req_type       req,
   input  crs_pkg::csr_out_type   csr_out,
   output crs_pkg::track_out_type track_out
);
   import crs_pkg::*;

   logic [31:0] frame_ff, frame_in;
   logic        recording_ff, recording_in;
   logic        end_pending_ff, end_pending_in;
   logic        cr_seen_ff, cr_seen_in;
   logic [2:0]  channel_ff, channel_in;
   logic [1:0]  position_ff, position_in;
   logic [3:0]  pending_ff, pending_in;

   logic [14:0] cc;
   logic [3:0]  limit;
   logic [1:0]  pos;
   logic [5:0]  lo;
   logic [3:0]  nib;
   logic [3:0]  hi;
   logic        is_ctrl, is_xds, xds_valid, starts, opened;
   logic [2:0]  ch;
   logic [4:0]  run;

   assign cc    = 15'({req.byte_high, req.byte_low} & PARITY_MASK);
   assign limit = (csr_out.null_cap < MAX_NULL_LIMIT) ? csr_out.null_cap : MAX_NULL_LIMIT;
   assign lo    = 6'(cc & LO_MASK);
   assign nib   = cc[3:0];
   assign hi    = 4'((cc & HI_MASK) >> 8);
   assign run   = {1'b0, pending_ff} + 5'd1;

   always_comb begin
      frame_in       = frame_ff + 32'd1;
      recording_in   = recording_ff;
      end_pending_in = end_pending_ff;
      cr_seen_in     = cr_seen_ff;
      channel_in     = channel_ff;
      position_in    = position_ff;
      pending_in     = pending_ff;
      pos            = position_ff;
      is_ctrl        = (cc | CTRL_OR) == CTRL_MATCH;
      is_xds         = (cc | XDS_OR) == XDS_OR;
      xds_valid      = is_xds && (hi != 4'd0);
      starts         = 1'b0;
      opened         = 1'b0;
      ch             = 3'd1;
      track_out.valid     = 1'b0;
      track_out.job.word  = cc;
      track_out.job.frame = frame_ff;
      track_out.job.nulls = recording_ff ? pending_ff : 4'd0;
      track_out.job.start = 1'b0;

      if (cc == '0) begin
         if (recording_ff) begin
            if ((run > {1'b0, limit}) || end_pending_ff || cr_seen_ff) begin
               recording_in = 1'b0;
               pending_in   = 4'd0;
            end else begin
               pending_in  = run[3:0];
               position_in = (position_ff == 2'd3) ? 2'd3 : position_ff + 2'd1;
            end
            end_pending_in = 1'b0;
            cr_seen_in     = 1'b0;
         end
      end else begin
         track_out.valid = 1'b1;
         if (recording_ff) begin
            pos = (position_ff == 2'd3) ? 2'd3 : position_ff + 2'd1;
         end
         if (cr_seen_ff && ((cc | CR_OR) != CR_MATCH)) begin
            end_pending_in = 1'b0;
            recording_in   = 1'b0;
         end
         if (is_ctrl || is_xds) begin
            if (is_ctrl) begin
               starts = nib inside {4'h0, 4'h5, 4'h6, 4'h7, 4'h9, 4'ha, 4'hb};
            end
            if (xds_valid && (hi != XDS_END_HI)) begin
               starts = 1'b1;
            end
            if (starts) begin
               if ((is_ctrl && ((cc & FIELD_MASK) != '0)) || xds_valid) begin
                  ch = ch + 3'd2;
               end
               if (is_ctrl && ((cc & PAIR_MASK) != '0)) begin
                  ch = ch + 3'd1;
               end
               if ((pos >= 2'd2) && (channel_ff != ch)) begin
                  recording_in = 1'b0;
               end
               if (pos == 2'd3) begin
                  recording_in = 1'b0;
               end
               channel_in = ch;
            end
            if ((is_ctrl && ((lo == LO_EOC) || (lo == LO_EDM)))
                || (xds_valid && (hi == XDS_END_HI))) begin
               end_pending_in = 1'b1;
            end
            cr_seen_in = is_ctrl && (lo == LO_CR);
         end
         if (!recording_in) begin
            recording_in = 1'b1;
            pos          = 2'd1;
            opened       = 1'b1;
         end
         position_in = pos;
         pending_in  = 4'd0;
         track_out.job.start = opened;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff       <= RESET_START_FRAME;
         recording_ff   <= 1'b0;
         end_pending_ff <= 1'b0;
         cr_seen_ff     <= 1'b0;
         channel_ff     <= RESET_CHANNEL;
         position_ff    <= 2'd0;
         pending_ff     <= 4'd0;
      end else if (csr_out.frame_load) begin
         frame_ff <= csr_out.start_frame;
      end else if (step) begin
         frame_ff       <= frame_in;
         recording_ff   <= recording_in;
         end_pending_ff <= end_pending_in;
         cr_seen_ff     <= cr_seen_in;
         channel_ff     <= channel_in;
         position_ff    <= position_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

// ===== rtl/crs_emit.sv =====
module crs_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  crs_pkg::job_type job,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output crs_pkg::rsp_type rsp_data
);
   import crs_pkg::*;

   logic    valid_ff;
   job_type job_ff;
   logic    last;

   assign last      = (job_ff.nulls == 4'd0);
   assign free      = !valid_ff || (rsp_ready && last);
   assign rsp_valid = valid_ff;

   assign rsp_data.caption_word = last ? job_ff.word : 15'd0;
   assign rsp_data.record_start = last && job_ff.start;
   assign rsp_data.record_frame = job_ff.frame;
   assign rsp_data.run_last     = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (valid_ff && rsp_ready && last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end else if (valid_ff && rsp_ready && !last) begin
         job_ff.nulls <= job_ff.nulls - 4'd1;
      end
   end

endmodule

// ===== tb/caption_record_segmenter_tb.sv =====
`timescale 1ns / 100ps

module caption_record_segmenter_tb;

   localparam int DRAIN_CYCLES = 24;
   // low nibbles of the control start codes: 0x20, 0x25-0x27, 0x29-0x2b
   localparam logic [15:0] START_NIBBLES = 16'h0ee1;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   crs_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   crs_pkg::rsp_type                    rsp_data;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [crs_pkg::CSR_ADDR_W-1:0]      paddr = '0;
   logic [crs_pkg::CSR_DATA_W-1:0]      pwdata = '0;
   logic [crs_pkg::CSR_DATA_W-1:0]      prdata;
   logic                                pready;

   // segmenter state as the testbench tracks it
   int          null_limit;
   logic [31:0] frame_count;
   logic        in_record;
   logic        end_pending;
   logic        cr_seen;
   logic [2:0]  channel;
   int          word_pos;
   int          null_backlog;

   crs_pkg::rsp_type expected_beats[$];
   int fail_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   caption_record_segmenter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** caption_record_segmenter: FAILED **");
      $finish;
   end

   function automatic void segment_pair(logic [7:0] hb, logic [7:0] lb);
      logic [14:0] cc;
      logic [31:0] frame;
      logic [5:0]  lo;
      logic [3:0]  nib;
      logic [3:0]  hi;
      logic        is_ctrl;
      logic        is_xds;
      logic        xds_ok;
      logic        starts;
      logic        opened;
      logic [2:0]  ch;
      int          limit;
      int          backlog;
      int          pos;
      crs_pkg::rsp_type beat;
      frame = frame_count;
      cc = {hb[6:0], 1'b0, lb[6:0]};
      limit = (null_limit < int'(crs_pkg::MAX_NULL_LIMIT)) ? null_limit
                                                          : int'(crs_pkg::MAX_NULL_LIMIT);
      frame_count = frame + 32'd1;
      starts = 1'b0;
      opened = 1'b0;
      if (cc == '0) begin
         if (in_record) begin
            if (null_backlog + 1 > limit || end_pending || cr_seen) begin
               in_record = 1'b0;
               null_backlog = 0;
            end else begin
               null_backlog++;
               if (word_pos < 3) word_pos++;
            end
            end_pending = 1'b0;
            cr_seen = 1'b0;
         end
         return;
      end
      backlog = in_record ? null_backlog : 0;
      pos = word_pos;
      if (in_record && pos < 3) pos++;
      // anything but another carriage return after a lone one ends the record
      if (cr_seen && ((cc | crs_pkg::CR_OR) != crs_pkg::CR_MATCH)) begin
         end_pending = 1'b0;
         in_record = 1'b0;
      end
      lo = 6'(cc & crs_pkg::LO_MASK);
      nib = cc[3:0];
      hi = 4'((cc & crs_pkg::HI_MASK) >> 8);
      is_ctrl = (cc | crs_pkg::CTRL_OR) == crs_pkg::CTRL_MATCH;
      is_xds = (cc | crs_pkg::XDS_OR) == crs_pkg::XDS_OR;
      xds_ok = is_xds && hi != 4'd0;
      if (is_ctrl || is_xds) begin
         if (is_ctrl) starts = START_NIBBLES[nib];
         if (xds_ok && hi != crs_pkg::XDS_END_HI) starts = 1'b1;
         if (starts) begin
            ch = 3'd1;
            if ((is_ctrl && (cc & crs_pkg::FIELD_MASK) != '0) || xds_ok) ch += 3'd2;
            if (is_ctrl && (cc & crs_pkg::PAIR_MASK) != '0) ch += 3'd1;
            if (pos >= 2 && channel != ch) in_record = 1'b0;
            if (pos >= 3) in_record = 1'b0;
            channel = ch;
         end
         if ((is_ctrl && (lo == crs_pkg::LO_EOC || lo == crs_pkg::LO_EDM)) ||
             (xds_ok && hi == crs_pkg::XDS_END_HI)) begin
            end_pending = 1'b1;
         end
         cr_seen = is_ctrl && lo == crs_pkg::LO_CR;
      end
      if (!in_record) begin
         in_record = 1'b1;
         pos = 1;
         opened = 1'b1;
      end
      word_pos = pos;
      null_backlog = 0;
      for (int k = 0; k < backlog; k++) begin
         beat = '{caption_word: '0, record_start: 1'b0, record_frame: frame, run_last: 1'b0};
         expected_beats.push_back(beat);
      end
      beat = '{caption_word: cc, record_start: opened, record_frame: frame, run_last: 1'b1};
      expected_beats.push_back(beat);
   endfunction

   always @(posedge clock) begin : rsp_check
      crs_pkg::rsp_type want;
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat: word %h", rsp_data.caption_word);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data.caption_word !== want.caption_word) begin
               $error("caption_word: expected %h, got %h",
                      want.caption_word, rsp_data.caption_word);
               fail_count++;
            end
            if (rsp_data.record_start !== want.record_start) begin
               $error("record_start: expected %b, got %b",
                      want.record_start, rsp_data.record_start);
               fail_count++;
            end
            if (rsp_data.record_frame !== want.record_frame) begin
               $error("record_frame: expected %h, got %h",
                      want.record_frame, rsp_data.record_frame);
               fail_count++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_data.run_last);
               fail_count++;
            end
         end
      end
   end

   task automatic send_pair(input logic [7:0] hb, input logic [7:0] lb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {hb, lb};
      do @(posedge clock); while (!req_ready);
      segment_pair(hb, lb);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input crs_pkg::csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= crs_pkg::CSR_ADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         crs_pkg::REG_NULL_CAP: begin
            null_limit = int'(value[3:0]);
         end
         crs_pkg::REG_START_FRAME: begin
            frame_count = value;
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic test_null_runs();
      send_pair(8'h80, 8'h00);   // null with no record open
      send_pair(8'hff, 8'hff);
      send_pair(8'h00, 8'h80);
      send_pair(8'h80, 8'h80);
      send_pair(8'h41, 8'hc2);   // backlog of two flushed ahead of this word
      send_pair(8'h00, 8'h00);
      send_pair(8'h00, 8'h00);
      send_pair(8'h00, 8'h00);   // one null too many closes the record
      send_pair(8'h00, 8'h01);
      drain_results();
   endtask

   task automatic test_control_codes();
      send_pair(8'h14, 8'h20);   // start code, channel 1
      send_pair(8'h9c, 8'ha5);   // channel change at word two
      send_pair(8'h48, 8'h49);
      send_pair(8'h15, 8'h2c);   // end of caption
      send_pair(8'h00, 8'h00);
      send_pair(8'h14, 8'h2d);   // carriage return
      send_pair(8'h1d, 8'h2d);
      send_pair(8'h20, 8'h21);   // lone carriage return ends the record
      send_pair(8'h22, 8'h23);
      send_pair(8'h14, 8'h29);
      send_pair(8'h30, 8'h31);
      send_pair(8'h32, 8'h33);
      send_pair(8'h14, 8'h29);   // start code past word two
      send_pair(8'h94, 8'h2f);
      drain_results();
   endtask

   task automatic test_xds_codes();
      send_pair(8'h01, 8'h03);
      send_pair(8'h8f, 8'h1d);   // xds end
      send_pair(8'h00, 8'h80);
      drain_results();
   endtask

   task automatic test_register_extremes();
      csr_write(crs_pkg::REG_NULL_CAP, 32'd0);
      csr_write(crs_pkg::REG_START_FRAME, 32'hffff_fffe);
      send_pair(8'h41, 8'h41);
      send_pair(8'h00, 8'h00);
      send_pair(8'h42, 8'h42);
      send_pair(8'h43, 8'h43);   // frame number has wrapped to zero on the previous pair
      drain_results();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall,
                                      input logic [3:0] nulls, input logic [31:0] base_frame,
                                      input int count);
      int sent;
      int roll;
      int run;
      logic [7:0] hb;
      logic [7:0] lb;
      csr_write(crs_pkg::REG_NULL_CAP, 32'(nulls));
      csr_write(crs_pkg::REG_START_FRAME, base_frame);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         run = 1;
         if (roll < 28) begin
            hb = 8'($urandom_range(8'h20, 8'h7f));
            lb = 8'($urandom_range(8'h7f));
         end else if (roll < 48) begin
            hb = 8'h14 | 8'($urandom_range(1)) | (8'($urandom_range(1)) << 3);
            lb = 8'h20 + 8'($urandom_range(15));
         end else if (roll < 56) begin
            hb = 8'h14 | 8'($urandom_range(1)) | (8'($urandom_range(1)) << 3);
            lb = 8'(crs_pkg::LO_CR);
         end else if (roll < 65) begin
            hb = 8'($urandom_range(1, 15));
            lb = 8'($urandom_range(8'h7f));
         end else if (roll < 85) begin
            hb = 8'h00;
            lb = 8'h00;
            run = $urandom_range(1, null_limit + 2);
         end else begin
            hb = 8'($urandom_range(255));
            lb = 8'($urandom_range(255));
         end
         repeat (run) begin
            send_pair({1'($urandom_range(1)), hb[6:0]}, {1'($urandom_range(1)), lb[6:0]});
         end
         sent += run;
      end
      drain_results();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      null_limit = int'(crs_pkg::RESET_NULL_CAP);
      frame_count = crs_pkg::RESET_START_FRAME;
      in_record = 1'b0;
      end_pending = 1'b0;
      cr_seen = 1'b0;
      channel = crs_pkg::RESET_CHANNEL;
      word_pos = 0;
      null_backlog = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_null_runs();
      test_control_codes();
      test_xds_codes();
      test_register_extremes();
      test_random_traffic(0, 0, 4'd0, 32'hffff_ffff, 62);
      test_random_traffic(56, 0, 4'd15, $urandom, 62);
      test_random_traffic(0, 56, 4'($urandom_range(15)), 32'd0, 62);
      test_random_traffic(26, 26, 4'($urandom_range(1, 6)), $urandom, 62);
      if (fail_count == 0 && expected_beats.size() == 0) begin
         $display("** caption_record_segmenter: PASSED **");
      end else begin
         $display("** caption_record_segmenter: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/crs_pkg.sv
rtl/crs_csr.sv
rtl/crs_track.sv
rtl/crs_emit.sv
rtl/caption_record_segmenter.sv
tb/caption_record_segmenter_tb.sv
